@@ rtl/core/cc20_pkg.sv @@
package cc20_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd5;

  typedef logic [31:0]          word_t;
  typedef logic [3:0][31:0]     row_t;
  typedef logic [3:0][3:0][31:0] mat_t;

  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  // sequencer to state matrix
  typedef struct packed {
    logic       load;
    logic       mix;
    logic       add;
    logic [1:0] cnt;
    logic       diag;
  } ctrl_t;

endpackage

@@ rtl/core/cc20_if.sv @@
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/core/cc20_arx.sv @@
module cc20_arx (
  input  cc20_pkg::word_t x,
  input  cc20_pkg::word_t y,
  input  cc20_pkg::word_t z,
  input  logic [1:0]      sel,
  output cc20_pkg::word_t sum,
  output cc20_pkg::word_t mix
);
  import cc20_pkg::*;

  word_t t;

  always_comb begin
    sum = x + y;
    t   = z ^ sum;
    case (sel)
      2'd0:    mix = {t[15:0], t[31:16]};
      2'd1:    mix = {t[19:0], t[31:20]};
      2'd2:    mix = {t[23:0], t[31:24]};
      default: mix = {t[24:0], t[31:25]};
    endcase
  end

endmodule

@@ rtl/core/cc20_seq.sv @@
module cc20_seq #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output cc20_pkg::ctrl_t ctrl,
  output logic            done
);
  import cc20_pkg::*;

  localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int RND_W  = $clog2(ROUNDS);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  typedef enum logic [1:0] {S_IDLE, S_MIX, S_ADD} state_t;

  state_t           state_r;
  logic [1:0]       cnt_r;
  logic [RND_W-1:0] rnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rnd_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          rnd_r <= '0;
          if (start) begin
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            if (rnd_r == LAST_RND) begin
              state_r <= S_ADD;
            end else begin
              rnd_r <= rnd_r + RND_W'(1);
            end
          end
        end
        S_ADD: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl.load = (state_r == S_IDLE) && start;
    ctrl.mix  = (state_r == S_MIX);
    ctrl.add  = (state_r == S_ADD);
    ctrl.cnt  = cnt_r;
    ctrl.diag = rnd_r[0];
    done      = ctrl.add && (cnt_r == 2'd3);
  end

endmodule

@@ rtl/core/cc20_matrix.sv @@
module cc20_matrix (
  input  logic            clk,
  input  cc20_pkg::ctrl_t ctrl,
  input  cc20_pkg::mat_t  init,
  input  logic [5:0]      pos,
  output logic [7:0]      ks_byte
);
  import cc20_pkg::*;

  mat_t  work_r, work_nxt, p;
  row_t  init_row, lx, ly, lz, lsum, lmix;
  word_t ks_word;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    cc20_arx u_lane (
      .x   (lx[i]),
      .y   (ly[i]),
      .z   (lz[i]),
      .sel (ctrl.cnt),
      .sum (lsum[i]),
      .mix (lmix[i])
    );
  end

  always_comb begin
    init_row = init[ctrl.cnt];
    if (ctrl.add) begin
      lx = work_r[0];
      ly = init_row;
      lz = '0;
    end else if (!ctrl.cnt[0]) begin
      lx = work_r[0];
      ly = work_r[1];
      lz = work_r[3];
    end else begin
      lx = work_r[2];
      ly = work_r[3];
      lz = work_r[1];
    end
  end

  // rows rotate across lanes at the end of each round, so lanes always see columns
  always_comb begin
    work_nxt = work_r;
    p        = work_r;
    if (ctrl.load) begin
      work_nxt = init;
    end else if (ctrl.add) begin
      work_nxt = {lsum, work_r[3], work_r[2], work_r[1]};
    end else if (ctrl.mix) begin
      if (!ctrl.cnt[0]) begin
        p[0] = lsum;
        p[3] = lmix;
      end else begin
        p[2] = lsum;
        p[1] = lmix;
      end
      work_nxt = p;
      if (ctrl.cnt == 2'd3) begin
        for (int j = 0; j < 4; j++) begin
          if (!ctrl.diag) begin
            work_nxt[1][j] = p[1][2'(j + 1)];
            work_nxt[3][j] = p[3][2'(j + 3)];
          end else begin
            work_nxt[1][j] = p[1][2'(j + 3)];
            work_nxt[3][j] = p[3][2'(j + 1)];
          end
          work_nxt[2][j] = p[2][2'(j + 2)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  always_comb begin
    ks_word = work_r[pos[5:4]][pos[3:2]];
    ks_byte = ks_word[{pos[1:0], 3'b000} +: 8];
  end

endmodule

@@ rtl/core/chacha20_stream_cipher.sv @@
// channel | dir | handshake     | payload
// in_if   | in  | valid / ready | data_byte[7:0], last_byte
// out_if  | out | valid / ready | out_byte[7:0], out_last
// cfg     | in  | cfg_we        | cfg_index[2:0], cfg_wdata[63:0]
//
// Byte inside a keystream block: accepted and its result registered at the same edge.
// Byte at a block start: on accept the matrix is loaded, then the four-lane ARX unit runs
// the rounds one quarter-round line per cycle, four feed-forward adds follow, and the result
// is registered in the emit state; the next request is taken once back in idle.
// Synchronous active-low reset clears key, nonce, counter, position and handshakes.
// A stalled result holds off the next request; in_if.ready is low while a block is made.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  cc20_in_if.sink                             in_if,
  cc20_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cc20_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_CALC, T_EMIT} state_t;

  state_t      state_r;
  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] counter_r, counter_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  data_r;
  logic        last_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        out_free, accept, start, emit, done;
  logic [7:0]  ks_byte, emit_data;
  logic        emit_last;
  mat_t        init;
  ctrl_t       ctrl;

  assign init = {nonce_hi_r, nonce_lo_r, counter_r,
                 key3_r, key2_r, key1_r, key0_r,
                 SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};

  assign out_free     = !out_valid_r || out_if.ready;
  assign in_if.ready  = (state_r == T_IDLE) && out_free;
  assign accept       = in_if.valid && in_if.ready;
  assign start        = accept && (pos_r == '0);
  assign emit         = (accept && (pos_r != '0)) || ((state_r == T_EMIT) && out_free);
  assign emit_data    = ((state_r == T_IDLE) ? in_if.data_byte : data_r) ^ ks_byte;
  assign emit_last    = (state_r == T_IDLE) ? in_if.last_byte : last_r;

  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.out_last = out_last_r;

  cc20_seq #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ctrl  (ctrl),
    .done  (done)
  );

  cc20_matrix u_matrix (
    .clk     (clk),
    .ctrl    (ctrl),
    .init    (init),
    .pos     (pos_r),
    .ks_byte (ks_byte)
  );

  always_comb begin
    pos_nxt     = pos_r;
    counter_nxt = counter_r;
    if (emit) begin
      if (emit_last) begin
        pos_nxt     = '0;
        counter_nxt = '0;
      end else begin
        pos_nxt = pos_r + 6'd1;
        if (pos_nxt == '0) begin
          counter_nxt = counter_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r     <= '0;
      key1_r     <= '0;
      key2_r     <= '0;
      key3_r     <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_0:    key0_r     <= cfg_wdata;
        REG_KEY_1:    key1_r     <= cfg_wdata;
        REG_KEY_2:    key2_r     <= cfg_wdata;
        REG_KEY_3:    key3_r     <= cfg_wdata;
        REG_NONCE_LO: nonce_lo_r <= cfg_wdata;
        REG_NONCE_HI: nonce_hi_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      counter_r   <= '0;
    end else begin
      pos_r     <= pos_nxt;
      counter_r <= counter_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (start) begin
            state_r <= T_CALC;
          end
        end
        T_CALC: begin
          if (done) begin
            state_r <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (out_free) begin
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_if.data_byte;
      last_r <= in_if.last_byte;
    end
    if (emit) begin
      out_byte_r <= emit_data;
      out_last_r <= emit_last;
    end
  end

endmodule

@@ rtl/core/cc20_checker.sv @@
module cc20_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);

  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending request");

  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd0 || pend_r == 2'd1)
    else $error("more than one request outstanding");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_byte  (out_if.out_byte)
);
